### src/rig_pkg.sv
// Package with shared types and constants of the random interval generator.
`timescale 1ns / 1ps
package rig_pkg;
   localparam logic [63:0] LCG_MUL      = 64'd151117737;
   localparam logic [63:0] LCG_ADD      = 64'd119785373;
   localparam logic [63:0] MIX_MUL_A    = 64'd119785373;
   localparam logic [63:0] MIX_ADD_A    = 64'd126792457;
   localparam logic [63:0] MIX_XOR_A    = 64'd187678878;
   localparam logic [63:0] MIX_MUL_B    = 64'd85689495;
   localparam logic [63:0] MIX_ADD_B    = 64'd63498502;
   localparam logic [63:0] MIX_XOR_B    = 64'd143537923;
   localparam logic [63:0] MIX_MUL_C    = 64'd151117737;
   localparam logic [63:0] MIX_ADD_C    = 64'd98781234;
   localparam logic [63:0] COUNTER_INIT = 64'd65654363;
   localparam int unsigned ROT_BITS     = 20;

   localparam logic OP_INTERVAL = 1'b0;
   localparam logic OP_RAW      = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [63:0] low_limit;
      logic [63:0] high_limit;
   } req_type;

   typedef struct packed {
      logic [63:0] random_value;
      logic        range_error;
   } rsp_type;

   // classified job handed from front to back
   typedef struct packed {
      logic        gen;
      logic        raw;
      logic        err;
      logic [63:0] low_limit;
      logic [63:0] span;
   } job_type;
endpackage

### src/rig_if.sv
// Valid/ready channel interface.
`timescale 1ns / 1ps
interface rig_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### src/rig_front.sv
// Front end: accept requests, classify them, push jobs into a two-entry queue.
`timescale 1ns / 1ps
module rig_front (
   input  logic             clock,
   input  logic             reset,
   rig_if.sink              req,
   output rig_pkg::job_type job_out,
   output logic             job_valid,
   input  logic             job_pop
);
   import rig_pkg::*;

   job_type    q_ff [2];
   job_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   job_type    job_new;

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign job_out   = q_ff[0];

   always_comb begin
      job_new.raw       = (req.payload.opcode == OP_RAW);
      job_new.err       = !job_new.raw && (req.payload.high_limit < req.payload.low_limit);
      job_new.gen       = job_new.raw
                          || (req.payload.high_limit > req.payload.low_limit);
      job_new.low_limit = req.payload.low_limit;
      job_new.span      = req.payload.high_limit - req.payload.low_limit;
   end

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (job_pop && job_valid) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = job_new;
         cnt_in          = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_max: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overflow");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !job_valid) else $error("pop from empty queue");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !push) else $error("push into full queue");
endmodule

### src/rig_back.sv
// Back end: LCG advance, mixing chain on a shared 32x32 multiplier, serial modulo.
`timescale 1ns / 1ps
module rig_back (
   input  logic             clock,
   input  logic             reset,
   input  rig_pkg::job_type job_in,
   input  logic             job_valid,
   output logic             job_pop,
   rig_if.source            rsp
);
   import rig_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MUL  = 4'd1;
   localparam logic [3:0] ST_ACC  = 4'd2;
   localparam logic [3:0] ST_POST = 4'd3;
   localparam logic [3:0] ST_DIV  = 4'd4;
   localparam logic [3:0] ST_OUT  = 4'd5;

   logic [3:0]  state_ff, state_in;
   logic [63:0] ctr_ff, ctr_in;
   logic [63:0] val_ff, val_in;
   logic [63:0] mulc_ff, mulc_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  part_ff, part_in;
   logic [1:0]  step_ff, step_in;
   logic [63:0] prod_ff, prod_in;
   logic [64:0] rem_ff, rem_in;
   logic [6:0]  bit_ff, bit_in;
   job_type     job_ff, job_in_r;
   logic        ovalid_ff, ovalid_in;
   rsp_type     out_ff, out_in;
   logic [31:0] ma, mb;
   logic [64:0] rem_sh;

   assign rsp.valid   = ovalid_ff;
   assign rsp.payload = out_ff;
   assign job_pop     = (state_ff == ST_IDLE) && job_valid && !ovalid_ff;

   // partial products: lo*lo, hi*lo, lo*hi (upper product drops out mod 2^64)
   always_comb begin
      unique case (part_ff)
         2'd0:    begin ma = val_ff[31:0];  mb = mulc_ff[31:0];  end
         2'd1:    begin ma = val_ff[63:32]; mb = mulc_ff[31:0];  end
         default: begin ma = val_ff[31:0];  mb = mulc_ff[63:32]; end
      endcase
   end

   always_comb begin
      rem_sh = {rem_ff[63:0], val_ff[63]};
   end

   always_comb begin
      state_in  = state_ff;
      ctr_in    = ctr_ff;
      val_in    = val_ff;
      mulc_in   = mulc_ff;
      acc_in    = acc_ff;
      part_in   = part_ff;
      step_in   = step_ff;
      prod_in   = {32'd0, ma} * {32'd0, mb};
      rem_in    = rem_ff;
      bit_in    = bit_ff;
      job_in_r  = job_ff;
      ovalid_in = ovalid_ff;
      out_in    = out_ff;
      if (rsp.valid && rsp.ready) begin
         ovalid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (job_pop) begin
               job_in_r = job_in;
               if (job_in.gen) begin
                  val_in   = ctr_ff;
                  mulc_in  = LCG_MUL;
                  acc_in   = LCG_ADD;
                  part_in  = 2'd0;
                  step_in  = 2'd0;
                  state_in = ST_MUL;
               end else begin
                  out_in.random_value = job_in.low_limit;
                  out_in.range_error  = job_in.err;
                  ovalid_in           = 1'b1;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            unique case (part_ff)
               2'd0:    acc_in = acc_ff + prod_ff;
               default: acc_in = acc_ff + {prod_ff[31:0], 32'd0};
            endcase
            if (part_ff == 2'd2) begin
               state_in = ST_POST;
            end else begin
               part_in  = part_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_POST: begin
            part_in  = 2'd0;
            state_in = ST_MUL;
            unique case (step_ff)
               2'd0: begin
                  ctr_in  = acc_ff;
                  val_in  = acc_ff;
                  mulc_in = MIX_MUL_A;
                  acc_in  = MIX_ADD_A;
                  step_in = 2'd1;
               end
               2'd1: begin
                  val_in  = ((acc_ff ^ MIX_XOR_A) << ROT_BITS)
                            | ((acc_ff ^ MIX_XOR_A) >> (64 - ROT_BITS));
                  mulc_in = MIX_MUL_B;
                  acc_in  = MIX_ADD_B;
                  step_in = 2'd2;
               end
               2'd2: begin
                  val_in  = ((acc_ff ^ MIX_XOR_B) << ROT_BITS)
                            | ((acc_ff ^ MIX_XOR_B) >> (64 - ROT_BITS));
                  mulc_in = MIX_MUL_C;
                  acc_in  = MIX_ADD_C;
                  step_in = 2'd3;
               end
               default: begin
                  if (job_ff.raw) begin
                     out_in.random_value = acc_ff;
                     out_in.range_error  = 1'b0;
                     state_in            = ST_OUT;
                  end else begin
                     val_in   = acc_ff;
                     rem_in   = 65'd0;
                     bit_in   = 7'd0;
                     state_in = ST_DIV;
                  end
               end
            endcase
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, job_ff.span}) begin
               rem_in = rem_sh - {1'b0, job_ff.span};
            end else begin
               rem_in = rem_sh;
            end
            val_in = {val_ff[62:0], 1'b0};
            bit_in = bit_ff + 7'd1;
            if (bit_ff == 7'd63) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!ovalid_in) begin
               if (!job_ff.raw) begin
                  out_in.random_value = job_ff.low_limit + rem_ff[63:0];
                  out_in.range_error  = 1'b0;
               end
               ovalid_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      mulc_ff <= mulc_in;
      acc_ff  <= acc_in;
      part_ff <= part_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      bit_ff  <= bit_in;
      job_ff  <= job_in_r;
      out_ff  <= out_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         ctr_ff    <= COUNTER_INIT;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ctr_ff    <= ctr_in;
         ovalid_ff <= ovalid_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && !rsp.ready) |=> (ovalid_ff && $stable(out_ff)))
      else $error("result dropped while stalled");
   a_ctr_still: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DIV || state_ff == ST_OUT) |=> $stable(ctr_ff))
      else $error("counter moved outside advance");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !job_ff.raw) |-> (rem_ff < {1'b0, job_ff.span}))
      else $error("remainder not below span");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !job_pop) else $error("pop while busy");
endmodule

### src/random_interval_generator_top.sv
// Top level of the random interval generator.
//
// Request channel (req_): opcode, low_limit, high_limit. Opcode 1 returns a
// raw 64-bit mixed random value; opcode 0 returns low + rnd mod (high - low).
// Response channel (rsp_): random_value, range_error (high below low).
// A front end classifies requests into a two-entry job queue; a back end
// runs the counter step and three mixing stages on one 32x32 multiplier,
// three partial products per 64-bit multiply, then a one-bit-per-cycle
// restoring modulo. Raw requests skip the modulo; an interval request
// with low >= high skips the generator and returns low from idle.
// One item is processed at a time: the back end takes a new job from
// the queue only when it is idle and its last result has been taken.
// Reset is synchronous: counter returns to 65654363, queue and output clear.
// When the receiver stalls the result is held, the back end waits and the
// queue absorbs up to two more requests before req_ready drops.
`timescale 1ns / 1ps
module random_interval_generator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [63:0] req_low_limit,
   input  logic [63:0] req_high_limit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_random_value,
   output logic        rsp_range_error
);
   import rig_pkg::*;

   rig_if #(.payload_type(req_type)) req_ch ();
   rig_if #(.payload_type(rsp_type)) rsp_ch ();
   job_type job;
   logic    job_valid;
   logic    job_pop;

   assign req_ch.valid              = req_valid;
   assign req_ch.payload.opcode     = req_opcode;
   assign req_ch.payload.low_limit  = req_low_limit;
   assign req_ch.payload.high_limit = req_high_limit;
   assign req_ready                 = req_ch.ready;
   assign rsp_valid                 = rsp_ch.valid;
   assign rsp_ch.ready              = rsp_ready;
   assign rsp_random_value          = rsp_ch.payload.random_value;
   assign rsp_range_error           = rsp_ch.payload.range_error;

   rig_front u_front (
      .clock, .reset, .req(req_ch.sink),
      .job_out(job), .job_valid, .job_pop
   );

   rig_back u_back (
      .clock, .reset, .job_in(job), .job_valid, .job_pop,
      .rsp(rsp_ch.source)
   );
endmodule
